// ===== sv/s2x_pkg.sv =====
package s2x_pkg;

    // Operation codes of an input transaction.
    localparam logic [1:0] OP_LOAD_CMF   = 2'd0;
    localparam logic [1:0] OP_LOAD_ILLUM = 2'd1;
    localparam logic [1:0] OP_SAMPLE     = 2'd2;

    // Configuration register indexes and port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_REFLECTIVE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMF_FIRST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CMF_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ILLUM_FIRST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ILLUM_COUNT = 3'd4;

    localparam logic [47:0] MAX48 = '1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [8:0]  table_index;
        logic [15:0] cmf_x_value;
        logic [15:0] cmf_y_value;
        logic [15:0] cmf_z_value;
        logic [15:0] illuminant_value;
        logic [10:0] wavelength_nm;
        logic [15:0] sample_value;
        logic        last_sample;
    } in_item_t;

    typedef struct packed {
        logic [47:0] x_value;
        logic [47:0] y_value;
        logic [47:0] z_value;
        logic        normalisation_zero;
    } out_item_t;

    typedef struct packed {
        logic        reflective_mode;
        logic [10:0] cmf_first_wavelength;
        logic [9:0]  cmf_entry_count;
        logic [10:0] illuminant_first_wavelength;
        logic [9:0]  illuminant_entry_count;
    } cfg_t;

    // Class of a queued command, decided by the front end.
    typedef enum logic [1:0] {
        KIND_CMF,
        KIND_ILLUM,
        KIND_SAMPLE
    } kind_t;

    typedef struct packed {
        kind_t    kind;
        in_item_t item;
    } cmd_t;

    function automatic logic [47:0] sat48(input logic [63:0] v);
        return (v[63:48] != '0) ? MAX48 : v[47:0];
    endfunction

    function automatic logic [63:0] sat_add64(input logic [63:0] s, input logic [63:0] t);
        logic [64:0] r;
        r = {1'b0, s} + {1'b0, t};
        return r[64] ? '1 : r[63:0];
    endfunction

endpackage

// ===== sv/s2x_stream_if.sv =====
interface s2x_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/spectrum_to_xyz_integrator_unit.sv =====
// Spectrum to CIE XYZ integrator. Table loads and spectrum samples enter as
// transactions on in_ch; a two-entry command queue separates the input side
// from the integration sequencer, and a result register separates it from
// out_ch. A table load is written as it leaves the queue while the sequencer
// is idle. A sample whose interval covers table steps first runs a setup state
// and two 16-step divisions, each with its own start state, to prepare the
// interpolation; then the single CMF/illuminant read port and the multiply
// pipeline take one nm step per cycle. A sample with no steps that is not the
// last leaves the sequencer idle. The last sample of a spectrum adds a drain of
// the step pipeline and, in reflective mode with a nonzero illuminant-weighted
// Y sum, three 64-step divisions by that sum before the result is ready.
module spectrum_to_xyz_integrator_unit import s2x_pkg::*; #(
    parameter int CMF_DEPTH        = 512,
    parameter int ILLUMINANT_DEPTH = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    s2x_stream_if.sink            in_ch,
    s2x_stream_if.source          out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic cmd_valid;
    logic pop;
    cmd_t cmd;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_REFLECTIVE:  cfg_next.reflective_mode = cfg_data[0];
                CFG_CMF_FIRST:   cfg_next.cmf_first_wavelength = cfg_data[10:0];
                CFG_CMF_COUNT:   cfg_next.cmf_entry_count = cfg_data[9:0];
                CFG_ILLUM_FIRST: cfg_next.illuminant_first_wavelength = cfg_data[10:0];
                CFG_ILLUM_COUNT: cfg_next.illuminant_entry_count = cfg_data[9:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{reflective_mode: 1'b0,
                         cmf_first_wavelength: 11'd360,
                         cmf_entry_count: 10'd471,
                         illuminant_first_wavelength: 11'd360,
                         illuminant_entry_count: 10'd471};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    s2x_front #(
        .CMF_DEPTH        (CMF_DEPTH),
        .ILLUMINANT_DEPTH (ILLUMINANT_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .pop       (pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    s2x_back #(
        .CMF_DEPTH        (CMF_DEPTH),
        .ILLUMINANT_DEPTH (ILLUMINANT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .pop       (pop),
        .out_ch    (out_ch)
    );

endmodule

// ===== sv/s2x_ram.sv =====
module s2x_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/s2x_div.sv =====
module s2x_div #(
    parameter int NUM_W = 28,
    parameter int DEN_W = 11,
    parameter int QUO_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] shf_reg, shf_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;

    // Restoring division, one quotient bit per cycle. The caller guarantees
    // that the numerator bits above the quotient are below the divisor.
    always_comb
    begin
        trial     = {rem_reg, shf_reg[QUO_W-1]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        shf_next  = shf_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QUO_W);
            rem_next  = DEN_W'(num[NUM_W-1:QUO_W]);
            shf_next  = num[QUO_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[DEN_W-1:0];
                shf_next = {shf_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                shf_next = {shf_reg[QUO_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = shf_reg;
    assign rem  = rem_reg;

endmodule

// ===== sv/s2x_front.sv =====
module s2x_front import s2x_pkg::*; #(
    parameter int CMF_DEPTH        = 512,
    parameter int ILLUMINANT_DEPTH = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    s2x_stream_if.sink        in_ch,
    input  logic              pop,
    output logic              cmd_valid,
    output cmd_t              cmd
);

    cmd_t       slots_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    logic       keep;
    kind_t      kind;

    assign in_ch.ready = (count_reg != 2'd2);
    assign accept      = in_ch.valid && in_ch.ready;

    // Classify the transaction; unused codes and loads past a table are dropped.
    always_comb
    begin
        kind = KIND_SAMPLE;
        keep = 1'b0;
        case (in_ch.payload.operation)
            OP_LOAD_CMF:
            begin
                kind = KIND_CMF;
                keep = 32'(in_ch.payload.table_index) < CMF_DEPTH;
            end
            OP_LOAD_ILLUM:
            begin
                kind = KIND_ILLUM;
                keep = 32'(in_ch.payload.table_index) < ILLUMINANT_DEPTH;
            end
            OP_SAMPLE:
            begin
                kind = KIND_SAMPLE;
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // Two-entry queue toward the back end.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && keep)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        count_next = count_reg + 2'(accept && keep) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            slots_reg[wr_ptr_reg] <= '{kind: kind, item: in_ch.payload};
        end
    end

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slots_reg[rd_ptr_reg];

endmodule

// ===== sv/s2x_back.sv =====
module s2x_back import s2x_pkg::*; #(
    parameter int CMF_DEPTH        = 512,
    parameter int ILLUMINANT_DEPTH = 512
) (
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  logic         cmd_valid,
    input  cmd_t         cmd,
    output logic         pop,
    s2x_stream_if.source out_ch
);

    localparam int CA_W = $clog2(CMF_DEPTH);
    localparam int IA_W = $clog2(ILLUMINANT_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE      = 11'b000_0000_0001,
        S_SETUP     = 11'b000_0000_0010,
        S_DIVA_GO   = 11'b000_0000_0100,
        S_DIVA_WAIT = 11'b000_0000_1000,
        S_DIVB_GO   = 11'b000_0001_0000,
        S_DIVB_WAIT = 11'b000_0010_0000,
        S_RUN       = 11'b000_0100_0000,
        S_FINISH    = 11'b000_1000_0000,
        S_QGO       = 11'b001_0000_0000,
        S_QWAIT     = 11'b010_0000_0000,
        S_OUT       = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Spectrum state.
    logic [10:0] prev_wl_reg, prev_wl_next;
    logic [15:0] prev_val_reg, prev_val_next;
    logic        have_prev_reg, have_prev_next;
    logic [63:0] sx_reg, sx_next, sy_reg, sy_next, sz_reg, sz_next, sn_reg, sn_next;

    // Interval walk.
    logic [10:0] a_reg, a_next, b_reg, b_next;
    logic [15:0] va_reg, va_next, vb_reg, vb_next, vmax_reg, vmax_next;
    logic [10:0] span_reg, span_next;
    logic [15:0] dabs_reg, dabs_next;
    logic        dneg_reg, dneg_next;
    logic        last_reg, last_next;
    logic [10:0] x_reg, x_next, xlast_reg, xlast_next;
    logic [27:0] num_reg, num_next;
    logic [15:0] q_reg, q_next, dq_reg, dq_next;
    logic [10:0] r_reg, r_next, dr_reg, dr_next;

    // Result forming.
    logic [1:0]  sel_reg, sel_next;
    out_item_t   res_reg, res_next;
    out_item_t   out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    // Step pipeline.
    logic        pv0_reg, pv0_next, pv1_reg, pv2_reg;
    logic [15:0] v0_reg, v0_next;
    logic        refl0_reg, refl0_next, refl1_reg, refl2_reg;
    logic [31:0] m1_reg;
    logic [47:0] c1_reg;
    logic [15:0] il1_reg;
    logic [47:0] px2_reg, py2_reg, pz2_reg;
    logic [31:0] pn2_reg;
    logic        pipe_busy;

    // Table memories.
    logic            cmf_we, ill_we;
    logic [CA_W-1:0] cmf_waddr, cmf_raddr;
    logic [IA_W-1:0] ill_waddr, ill_raddr;
    logic [47:0]     cmf_rdata;
    logic [15:0]     ill_rdata;

    // Dividers.
    logic        idiv_start, idiv_done;
    logic [27:0] idiv_num;
    logic [15:0] idiv_quo;
    logic [10:0] idiv_rem;
    logic        fdiv_start, fdiv_done;
    logic [64:0] fdiv_num;
    logic [63:0] fdiv_quo;

    // Interval clipping.
    logic signed [13:0] s_a, s_b, c_lo, c_hi, i_lo, i_hi, lo_w, hi_w, stop_w;
    logic [13:0]        c_cnt, i_cnt;
    logic               nonempty;

    // Incremental interpolation update.
    logic [11:0] rs;
    logic [16:0] dsigned;

    s2x_ram #(.WIDTH(48), .DEPTH(CMF_DEPTH)) u_cmf_ram (
        .clk   (clk),
        .we    (cmf_we),
        .waddr (cmf_waddr),
        .wdata ({cmd.item.cmf_x_value, cmd.item.cmf_y_value, cmd.item.cmf_z_value}),
        .raddr (cmf_raddr),
        .rdata (cmf_rdata)
    );

    s2x_ram #(.WIDTH(16), .DEPTH(ILLUMINANT_DEPTH)) u_ill_ram (
        .clk   (clk),
        .we    (ill_we),
        .waddr (ill_waddr),
        .wdata (cmd.item.illuminant_value),
        .raddr (ill_raddr),
        .rdata (ill_rdata)
    );

    s2x_div #(.NUM_W(28), .DEN_W(11), .QUO_W(16)) u_interp_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (idiv_start),
        .num   (idiv_num),
        .den   (span_reg),
        .done  (idiv_done),
        .quo   (idiv_quo),
        .rem   (idiv_rem)
    );

    s2x_div #(.NUM_W(65), .DEN_W(64), .QUO_W(64)) u_norm_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (fdiv_start),
        .num   (fdiv_num),
        .den   (sn_reg),
        .done  (fdiv_done),
        .quo   (fdiv_quo),
        .rem   ()
    );

    assign pipe_busy = pv0_reg || pv1_reg || pv2_reg;

    // Table writes happen as load commands leave the queue.
    assign pop       = (state_reg == S_IDLE) && cmd_valid;
    assign cmf_we    = pop && (cmd.kind == KIND_CMF);
    assign ill_we    = pop && (cmd.kind == KIND_ILLUM);
    assign cmf_waddr = CA_W'(32'(cmd.item.table_index));
    assign ill_waddr = IA_W'(32'(cmd.item.table_index));
    assign cmf_raddr = CA_W'(11'(x_reg - cfg.cmf_first_wavelength));
    assign ill_raddr = IA_W'(11'(x_reg - cfg.illuminant_first_wavelength));

    assign idiv_start = (state_reg == S_DIVA_GO) || (state_reg == S_DIVB_GO);
    assign idiv_num   = (state_reg == S_DIVA_GO) ? num_reg : 28'(dabs_reg);
    assign fdiv_start = (state_reg == S_QGO);
    always_comb
    begin
        case (sel_reg)
            2'd0:    fdiv_num = {1'b0, sx_reg};
            2'd1:    fdiv_num = {1'b0, sy_reg};
            default: fdiv_num = {1'b0, sz_reg};
        endcase
    end

    // Clip the interval from the previous sample to the new one.
    always_comb
    begin
        s_a   = $signed({3'b000, prev_wl_reg});
        s_b   = $signed({3'b000, cmd.item.wavelength_nm});
        c_cnt = (32'(cfg.cmf_entry_count) > CMF_DEPTH) ? 14'(CMF_DEPTH)
                                                       : {4'b0, cfg.cmf_entry_count};
        i_cnt = (32'(cfg.illuminant_entry_count) > ILLUMINANT_DEPTH)
                ? 14'(ILLUMINANT_DEPTH) : {4'b0, cfg.illuminant_entry_count};
        c_lo  = $signed({3'b000, cfg.cmf_first_wavelength});
        i_lo  = $signed({3'b000, cfg.illuminant_first_wavelength});
        c_hi  = c_lo + $signed(c_cnt) - 14'sd1;
        i_hi  = i_lo + $signed(i_cnt) - 14'sd1;
        lo_w  = (s_a < c_lo) ? c_lo : s_a;
        hi_w  = (s_b > c_hi) ? c_hi : s_b;
        if (cfg.reflective_mode)
        begin
            if (lo_w < i_lo)
            begin
                lo_w = i_lo;
            end
            if (hi_w > i_hi)
            begin
                hi_w = i_hi;
            end
        end
        stop_w   = cmd.item.last_sample ? hi_w + 14'sd1 : hi_w;
        nonempty = have_prev_reg && (lo_w < stop_w);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        prev_wl_next   = prev_wl_reg;
        prev_val_next  = prev_val_reg;
        have_prev_next = have_prev_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        vmax_next      = vmax_reg;
        span_next      = span_reg;
        dabs_next      = dabs_reg;
        dneg_next      = dneg_reg;
        last_next      = last_reg;
        x_next         = x_reg;
        xlast_next     = xlast_reg;
        num_next       = num_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        dq_next        = dq_reg;
        dr_next        = dr_reg;
        sel_next       = sel_reg;
        res_next       = res_reg;
        pv0_next       = 1'b0;
        v0_next        = q_reg;
        refl0_next     = cfg.reflective_mode;
        rs             = '0;
        dsigned        = {1'b0, cmd.item.sample_value} - {1'b0, prev_val_reg};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && (cmd.kind == KIND_SAMPLE))
                begin
                    a_next     = prev_wl_reg;
                    b_next     = cmd.item.wavelength_nm;
                    va_next    = prev_val_reg;
                    vb_next    = cmd.item.sample_value;
                    vmax_next  = (cmd.item.sample_value > prev_val_reg)
                                 ? cmd.item.sample_value : prev_val_reg;
                    dneg_next  = dsigned[16];
                    dabs_next  = dsigned[16] ? 16'(-dsigned) : dsigned[15:0];
                    last_next  = cmd.item.last_sample;
                    x_next     = 11'(lo_w);
                    xlast_next = 11'(stop_w - 14'sd1);
                    prev_wl_next   = cmd.item.wavelength_nm;
                    prev_val_next  = cmd.item.sample_value;
                    have_prev_next = 1'b1;
                    if (nonempty)
                    begin
                        if (cmd.item.wavelength_nm > prev_wl_reg)
                        begin
                            span_next  = cmd.item.wavelength_nm - prev_wl_reg;
                            state_next = S_SETUP;
                        end
                        else
                        begin
                            // Zero-width closing interval: one step at the previous value.
                            span_next  = 11'd1;
                            q_next     = prev_val_reg;
                            r_next     = '0;
                            dq_next    = '0;
                            dr_next    = '0;
                            dneg_next  = 1'b0;
                            state_next = S_RUN;
                        end
                    end
                    else if (cmd.item.last_sample)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SETUP:
            begin
                num_next = 28'(va_reg * 27'(b_reg - x_reg))
                         + 28'(vb_reg * 27'(x_reg - a_reg))
                         + 28'(span_reg >> 1);
                state_next = S_DIVA_GO;
            end

            S_DIVA_GO:
            begin
                state_next = S_DIVA_WAIT;
            end

            S_DIVA_WAIT:
            begin
                if (idiv_done)
                begin
                    q_next     = idiv_quo;
                    r_next     = idiv_rem;
                    state_next = S_DIVB_GO;
                end
            end

            S_DIVB_GO:
            begin
                state_next = S_DIVB_WAIT;
            end

            S_DIVB_WAIT:
            begin
                if (idiv_done)
                begin
                    dq_next    = idiv_quo;
                    dr_next    = idiv_rem;
                    state_next = S_RUN;
                end
            end

            S_RUN:
            begin
                // Issue one nm step and advance the interpolated value.
                pv0_next = 1'b1;
                if (!dneg_reg)
                begin
                    rs = {1'b0, r_reg} + {1'b0, dr_reg};
                    if (rs >= {1'b0, span_reg})
                    begin
                        r_next = 11'(rs - {1'b0, span_reg});
                        q_next = q_reg + dq_reg + 16'd1;
                    end
                    else
                    begin
                        r_next = rs[10:0];
                        q_next = q_reg + dq_reg;
                    end
                end
                else
                begin
                    rs = {1'b0, r_reg} - {1'b0, dr_reg};
                    if (rs[11])
                    begin
                        r_next = 11'(rs + {1'b0, span_reg});
                        q_next = q_reg - dq_reg - 16'd1;
                    end
                    else
                    begin
                        r_next = rs[10:0];
                        q_next = q_reg - dq_reg;
                    end
                end
                x_next = x_reg + 11'd1;
                if (x_reg == xlast_reg)
                begin
                    state_next = last_reg ? S_FINISH : S_IDLE;
                end
            end

            S_FINISH:
            begin
                if (!pipe_busy)
                begin
                    if (!cfg.reflective_mode)
                    begin
                        res_next   = '{x_value: sat48(sx_reg), y_value: sat48(sy_reg),
                                       z_value: sat48(sz_reg), normalisation_zero: 1'b0};
                        state_next = S_OUT;
                    end
                    else if (sn_reg == '0)
                    begin
                        res_next   = '{x_value: '0, y_value: '0, z_value: '0,
                                       normalisation_zero: 1'b1};
                        state_next = S_OUT;
                    end
                    else
                    begin
                        res_next.normalisation_zero = 1'b0;
                        sel_next   = 2'd0;
                        state_next = S_QGO;
                    end
                end
            end

            S_QGO:
            begin
                state_next = S_QWAIT;
            end

            S_QWAIT:
            begin
                if (fdiv_done)
                begin
                    case (sel_reg)
                        2'd0:    res_next.x_value = sat48(fdiv_quo);
                        2'd1:    res_next.y_value = sat48(fdiv_quo);
                        default: res_next.z_value = sat48(fdiv_quo);
                    endcase
                    if (sel_reg == 2'd2)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        sel_next   = sel_reg + 2'd1;
                        state_next = S_QGO;
                    end
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    prev_wl_next   = '0;
                    prev_val_next  = '0;
                    have_prev_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Accumulators: the last pipeline stage adds, a result moved into the output register clears.
    always_comb
    begin
        sx_next = sx_reg;
        sy_next = sy_reg;
        sz_next = sz_reg;
        sn_next = sn_reg;
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ch.ready))
        begin
            sx_next = '0;
            sy_next = '0;
            sz_next = '0;
            sn_next = '0;
        end
        else if (pv2_reg)
        begin
            sx_next = sat_add64(sx_reg, 64'(px2_reg));
            sy_next = sat_add64(sy_reg, 64'(py2_reg));
            sz_next = sat_add64(sz_reg, 64'(pz2_reg));
            if (refl2_reg)
            begin
                sn_next = sat_add64(sn_reg, 64'(pn2_reg));
            end
        end
    end

    // Output register.
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        if ((state_reg == S_OUT) && (!out_valid_reg || out_ch.ready))
        begin
            out_next       = res_reg;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_wl_reg   <= '0;
            prev_val_reg  <= '0;
            have_prev_reg <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            sz_reg        <= '0;
            sn_reg        <= '0;
            out_valid_reg <= 1'b0;
            pv0_reg       <= 1'b0;
            pv1_reg       <= 1'b0;
            pv2_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_wl_reg   <= prev_wl_next;
            prev_val_reg  <= prev_val_next;
            have_prev_reg <= have_prev_next;
            sx_reg        <= sx_next;
            sy_reg        <= sy_next;
            sz_reg        <= sz_next;
            sn_reg        <= sn_next;
            out_valid_reg <= out_valid_next;
            pv0_reg       <= pv0_next;
            pv1_reg       <= pv0_reg;
            pv2_reg       <= pv1_reg;
        end
    end

    // Datapath registers; the step pipeline forms the weight, then the products.
    always_ff @(posedge clk)
    begin
        a_reg     <= a_next;
        b_reg     <= b_next;
        va_reg    <= va_next;
        vb_reg    <= vb_next;
        vmax_reg  <= vmax_next;
        span_reg  <= span_next;
        dabs_reg  <= dabs_next;
        dneg_reg  <= dneg_next;
        last_reg  <= last_next;
        x_reg     <= x_next;
        xlast_reg <= xlast_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        dq_reg    <= dq_next;
        dr_reg    <= dr_next;
        sel_reg   <= sel_next;
        res_reg   <= res_next;
        out_reg   <= out_next;

        v0_reg    <= v0_next;
        refl0_reg <= refl0_next;

        m1_reg    <= refl0_reg ? 32'(ill_rdata) * 32'(v0_reg) : 32'(v0_reg);
        c1_reg    <= cmf_rdata;
        il1_reg   <= ill_rdata;
        refl1_reg <= refl0_reg;

        px2_reg   <= 48'(c1_reg[47:32]) * 48'(m1_reg);
        py2_reg   <= 48'(c1_reg[31:16]) * 48'(m1_reg);
        pz2_reg   <= 48'(c1_reg[15:0]) * 48'(m1_reg);
        pn2_reg   <= 32'(il1_reg) * 32'(c1_reg[31:16]);
        refl2_reg <= refl1_reg;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

`ifndef ASSERT_OFF
    a_run_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (x_reg <= xlast_reg))
        else $error("step position ran past the end of the interval");

    a_interp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (q_reg <= vmax_reg))
        else $error("interpolated value exceeds both end samples");

    a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !pipe_busy)
        else $error("result formed while steps were still in flight");
`endif

endmodule

// ===== sim/spectrum_to_xyz_integrator_unit_tb.sv =====
module spectrum_to_xyz_integrator_unit_tb;
    import s2x_pkg::*;

    localparam int TBL_DEPTH   = 512;
    localparam int DRAIN_WAIT  = 800;
    localparam int STALL_LIMIT = 6000;

    // One row of the directed stimulus table.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    s2x_stream_if #(.payload_t(in_item_t))  in_ch ();
    s2x_stream_if #(.payload_t(out_item_t)) out_ch ();

    spectrum_to_xyz_integrator_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow of the tables, registers and spectrum accumulators.
    logic [15:0] shadow_cx [TBL_DEPTH];
    logic [15:0] shadow_cy [TBL_DEPTH];
    logic [15:0] shadow_cz [TBL_DEPTH];
    logic [15:0] shadow_il [TBL_DEPTH];
    cfg_t        shadow_cfg;
    logic [10:0] prev_wl;
    logic [15:0] prev_val;
    bit          prev_valid;
    logic [63:0] acc_x, acc_y, acc_z, acc_norm;

    out_item_t xyz_expected_q [$];
    stim_row_t directed_rows [$];

    bit        typed_row;
    out_item_t typed_res;
    bit        calm;
    int        error_count;
    int        items_sent;
    int        results_seen;
    int        refl_results;
    int        zero_norm_results;
    int        phases_run;
    int        idle_cycles;

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic logic [63:0] add_clamped(input logic [63:0] s, input logic [63:0] t);
        logic [64:0] r;
        r = {1'b0, s} + {1'b0, t};
        return r[64] ? {64{1'b1}} : r[63:0];
    endfunction

    function automatic logic [47:0] clamp48(input logic [63:0] v);
        return (v > {16'd0, MAX48}) ? MAX48 : v[47:0];
    endfunction

    // Linear interpolation of the spectrum at nm x, rounded to nearest.
    function automatic int unsigned interp_value(input int x, input int a, input int b,
                                                 input int unsigned va, input int unsigned vb);
        int unsigned span;
        int unsigned num;
        if (b <= a)
        begin
            return va;
        end
        span = b - a;
        num = va * (b - x) + vb * (x - a) + span / 2;
        return num / span;
    endfunction

    // Accumulates every nm step of one interval into the running sums.
    function automatic void accumulate_interval(input int a, input int unsigned va,
                                                input int b, input int unsigned vb,
                                                input bit closing);
        int unsigned ccnt;
        int unsigned icnt;
        int cfirst;
        int ifirst;
        int lo;
        int hi;
        int stop;
        int unsigned ci;
        int unsigned ii;
        logic [63:0] v;
        logic [63:0] il;
        logic [63:0] w;
        ccnt = (int'(shadow_cfg.cmf_entry_count) > TBL_DEPTH) ? TBL_DEPTH
                                                              : int'(shadow_cfg.cmf_entry_count);
        icnt = (int'(shadow_cfg.illuminant_entry_count) > TBL_DEPTH)
               ? TBL_DEPTH : int'(shadow_cfg.illuminant_entry_count);
        cfirst = int'(shadow_cfg.cmf_first_wavelength);
        ifirst = int'(shadow_cfg.illuminant_first_wavelength);
        lo = a;
        hi = b;
        if (lo < cfirst) lo = cfirst;
        if (hi > cfirst + int'(ccnt) - 1) hi = cfirst + int'(ccnt) - 1;
        if (shadow_cfg.reflective_mode)
        begin
            if (lo < ifirst) lo = ifirst;
            if (hi > ifirst + int'(icnt) - 1) hi = ifirst + int'(icnt) - 1;
        end
        stop = closing ? hi + 1 : hi;
        for (int x = lo; x < stop; x++)
        begin
            ci = x - cfirst;
            if (ci >= TBL_DEPTH) break;
            v = 64'(interp_value(x, a, b, va, vb));
            if (!shadow_cfg.reflective_mode)
            begin
                acc_x = add_clamped(acc_x, shadow_cx[ci] * v);
                acc_y = add_clamped(acc_y, shadow_cy[ci] * v);
                acc_z = add_clamped(acc_z, shadow_cz[ci] * v);
            end
            else
            begin
                ii = x - ifirst;
                if (ii >= TBL_DEPTH) break;
                il = 64'(shadow_il[ii]);
                w = il * v;
                acc_norm = add_clamped(acc_norm, il * shadow_cy[ci]);
                acc_x = add_clamped(acc_x, shadow_cx[ci] * w);
                acc_y = add_clamped(acc_y, shadow_cy[ci] * w);
                acc_z = add_clamped(acc_z, shadow_cz[ci] * w);
            end
        end
    endfunction

    // Applies one accepted transaction; returns 1 when it yields a result.
    function automatic bit predict_xyz(input in_item_t it, output out_item_t res);
        res = '0;
        if (it.operation == OP_LOAD_CMF)
        begin
            shadow_cx[it.table_index] = it.cmf_x_value;
            shadow_cy[it.table_index] = it.cmf_y_value;
            shadow_cz[it.table_index] = it.cmf_z_value;
            return 1'b0;
        end
        if (it.operation == OP_LOAD_ILLUM)
        begin
            shadow_il[it.table_index] = it.illuminant_value;
            return 1'b0;
        end
        if (it.operation != OP_SAMPLE)
        begin
            return 1'b0;
        end
        if (prev_valid)
        begin
            accumulate_interval(int'(prev_wl), 32'(prev_val), int'(it.wavelength_nm),
                                32'(it.sample_value), it.last_sample);
        end
        prev_wl = it.wavelength_nm;
        prev_val = it.sample_value;
        prev_valid = 1'b1;
        if (!it.last_sample)
        begin
            return 1'b0;
        end
        if (!shadow_cfg.reflective_mode)
        begin
            res.x_value = clamp48(acc_x);
            res.y_value = clamp48(acc_y);
            res.z_value = clamp48(acc_z);
        end
        else if (acc_norm == 64'd0)
        begin
            res.normalisation_zero = 1'b1;
        end
        else
        begin
            res.x_value = clamp48(acc_x / acc_norm);
            res.y_value = clamp48(acc_y / acc_norm);
            res.z_value = clamp48(acc_z / acc_norm);
        end
        prev_wl = '0;
        prev_val = '0;
        prev_valid = 1'b0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        acc_norm = '0;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        error_count++;
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    endtask

    // Monitor: register writes, accepted inputs and accepted results.
    always @(posedge clk)
    begin
        out_item_t res;
        out_item_t want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REFLECTIVE:  shadow_cfg.reflective_mode = cfg_data[0];
                    CFG_CMF_FIRST:   shadow_cfg.cmf_first_wavelength = cfg_data[10:0];
                    CFG_CMF_COUNT:   shadow_cfg.cmf_entry_count = cfg_data[9:0];
                    CFG_ILLUM_FIRST: shadow_cfg.illuminant_first_wavelength = cfg_data[10:0];
                    CFG_ILLUM_COUNT: shadow_cfg.illuminant_entry_count = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (predict_xyz(in_ch.payload, res))
                begin
                    xyz_expected_q.push_back(typed_row ? typed_res : res);
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (xyz_expected_q.size() == 0)
                begin
                    error_count++;
                    $display("MISMATCH: result transaction with no expectation waiting");
                end
                else
                begin
                    want = xyz_expected_q.pop_front();
                    if (want.normalisation_zero) zero_norm_results++;
                    if (out_ch.payload.x_value !== want.x_value)
                        report_mismatch("x_value", out_ch.payload.x_value, want.x_value);
                    if (out_ch.payload.y_value !== want.y_value)
                        report_mismatch("y_value", out_ch.payload.y_value, want.y_value);
                    if (out_ch.payload.z_value !== want.z_value)
                        report_mismatch("z_value", out_ch.payload.z_value, want.z_value);
                    if (out_ch.payload.normalisation_zero !== want.normalisation_zero)
                        report_mismatch("normalisation_zero",
                                        48'(out_ch.payload.normalisation_zero),
                                        48'(want.normalisation_zero));
                end
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (calm || r < 70) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // Result side back-pressure.
    always @(negedge clk)
    begin
        int stall;
        if (stall > 0)
        begin
            out_ch.ready <= 1'b0;
            stall--;
        end
        else
        begin
            out_ch.ready <= 1'b1;
            stall = pick_gap();
        end
    end

    task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        typed_row = typed;
        typed_res = res;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        if (it.operation != 2'd3) items_sent++;
    endtask

    task automatic send(input in_item_t it);
        send_item(it, 1'b0, '0);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_ch.valid <= 1'b0;
    endtask

    // Waits until every expected result is in and the block has gone quiet.
    task automatic drain();
        release_input();
        while (xyz_expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input bit refl, input int cf, input int cc,
                              input int ifw, input int ic);
        write_reg(CFG_REFLECTIVE, 32'(refl));
        write_reg(CFG_CMF_FIRST, cf);
        write_reg(CFG_CMF_COUNT, cc);
        write_reg(CFG_ILLUM_FIRST, ifw);
        write_reg(CFG_ILLUM_COUNT, ic);
    endtask

    function automatic in_item_t sample_item(input int wl, input int val, input bit last);
        in_item_t it;
        it = '0;
        it.operation = OP_SAMPLE;
        it.wavelength_nm = 11'(wl);
        it.sample_value = 16'(val);
        it.last_sample = last;
        return it;
    endfunction

    // An input transaction with every field random.
    function automatic in_item_t random_item();
        logic [127:0] raw;
        in_item_t     it;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(in_item_t)-1:0];
        return it;
    endfunction

    function automatic in_item_t random_load();
        in_item_t it;
        it = random_item();
        it.operation = $urandom_range(1) ? OP_LOAD_CMF : OP_LOAD_ILLUM;
        return it;
    endfunction

    function automatic void add_row(input in_item_t it, input bit typed);
        stim_row_t row;
        row.item = it;
        row.typed = typed;
        row.res = '0;
        directed_rows.push_back(row);
    endfunction

    // One phase of random spectra: mostly ascending runs, some noise.
    task automatic random_phase(input int n_items);
        int wl;
        int r;
        int base;
        in_item_t it;
        base = int'(shadow_cfg.cmf_first_wavelength);
        wl = base - 12 + $urandom_range(40);
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(99);
            if (r < 80)
            begin
                r = $urandom_range(99);
                if (r < 85) wl = wl + $urandom_range(10, 1);
                else if (r < 90) wl = wl;
                else if (r < 95) wl = wl - $urandom_range(20);
                else wl = wl + $urandom_range(120);
                if (wl < 0) wl = 0;
                if (wl > 2047) wl = 2047;
                it = sample_item(wl, $urandom_range(65535), $urandom_range(7) == 0);
                if (it.last_sample)
                begin
                    wl = base - 12 + $urandom_range(60);
                    if (wl < 0) wl = 0;
                end
                if ($urandom_range(9) == 0) it.sample_value = $urandom_range(1) ? 16'hFFFF : 16'h0;
            end
            else if (r < 90)
            begin
                it = random_load();
            end
            else if (r < 95)
            begin
                it = random_item();
                it.operation = 2'd3;
            end
            else
            begin
                it = random_item();
                it.operation = OP_SAMPLE;
            end
            send(it);
        end
        it = sample_item(wl, $urandom_range(65535), 1'b1);
        send(it);
        phases_run++;
    endtask

    initial
    begin
        in_item_t it;
        stim_row_t row;
        int cf;
        int ifw;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        out_ch.ready = 1'b0;
        typed_row = 1'b0;
        typed_res = '0;
        calm = 1'b0;
        shadow_cfg.reflective_mode = 1'b0;
        shadow_cfg.cmf_first_wavelength = 11'd360;
        shadow_cfg.cmf_entry_count = 10'd471;
        shadow_cfg.illuminant_first_wavelength = 11'd360;
        shadow_cfg.illuminant_entry_count = 10'd471;
        prev_wl = '0;
        prev_val = '0;
        prev_valid = 1'b0;
        acc_x = '0;
        acc_y = '0;
        acc_z = '0;
        acc_norm = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A single sample on a fresh spectrum gives zero sums; it reads no table.
        add_row(sample_item(2047, 16'hFFFF, 1'b1), 1'b1);
        // The unused operation with every field at its maximum is dropped.
        it = '1;
        add_row(it, 1'b0);
        // An interval wholly below the CMF range contributes nothing.
        add_row(sample_item(0, 0, 1'b0), 1'b0);
        add_row(sample_item(100, 16'hFFFF, 1'b1), 1'b1);
        run_directed_head();

        // Fill every table entry so that no read ever hits an unwritten one.
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            it = random_load();
            it.operation = OP_LOAD_CMF;
            it.table_index = 9'(i);
            send(it);
            it = random_load();
            it.operation = OP_LOAD_ILLUM;
            it.table_index = 9'(i);
            send(it);
        end

        // Directed rows that read the tables.
        it = '0;
        it.operation = OP_LOAD_CMF;
        it.table_index = 9'd511;
        it.cmf_x_value = 16'hFFFF;
        it.cmf_y_value = 16'hFFFF;
        it.cmf_z_value = 16'hFFFF;
        add_row(it, 1'b0);
        it.operation = OP_LOAD_ILLUM;
        it.illuminant_value = 16'hFFFF;
        add_row(it, 1'b0);
        it = '0;
        it.operation = OP_LOAD_CMF;
        add_row(it, 1'b0);
        // Equal wavelengths on the last interval: one step with the earlier value.
        add_row(sample_item(400, 16'hFFFF, 1'b0), 1'b0);
        add_row(sample_item(400, 0, 1'b1), 1'b0);
        // A descending interval adds nothing.
        add_row(sample_item(500, 16'h1234, 1'b0), 1'b0);
        add_row(sample_item(450, 16'hFFFF, 1'b1), 1'b1);
        // Intervals straddling the bottom and top of the CMF range.
        add_row(sample_item(355, 0, 1'b0), 1'b0);
        add_row(sample_item(365, 16'hFFFF, 1'b0), 1'b0);
        add_row(sample_item(368, 16'h8000, 1'b1), 1'b0);
        add_row(sample_item(825, 1, 1'b0), 1'b0);
        add_row(sample_item(840, 16'hFFFF, 1'b1), 1'b0);
        // A load in the middle of a spectrum leaves the sums alone.
        add_row(sample_item(360, 16'hFFFF, 1'b0), 1'b0);
        add_row(random_load(), 1'b0);
        add_row(sample_item(361, 16'h00FF, 1'b1), 1'b0);
        run_directed_head();
        drain();

        // Reflective mode with an empty illuminant range flags the zero sum.
        set_config(1'b1, 360, 471, 360, 0);
        add_row(sample_item(400, 16'hFFFF, 1'b0), 1'b0);
        row.res = '0;
        row.res.normalisation_zero = 1'b1;
        row.item = sample_item(410, 16'hFFFF, 1'b1);
        row.typed = 1'b1;
        directed_rows.push_back(row);
        run_directed_head();
        drain();

        // Random phases under a range of register settings, extremes included.
        set_config(1'b0, 360, 471, 360, 471);
        random_phase(80);
        drain();
        set_config(1'b1, 380, 400, 370, 420);
        calm = 1'b1;
        random_phase(80);
        release_input();
        // Hold off until every outstanding result has come back.
        while (xyz_expected_q.size() != 0) @(posedge clk);
        calm = 1'b0;
        random_phase(50);
        drain();
        set_config(1'b0, 0, 0, 0, 0);
        random_phase(40);
        drain();
        set_config(1'b1, 0, 1023, 0, 1023);
        random_phase(80);
        drain();
        set_config(1'b0, 2047, 1023, 2047, 1023);
        random_phase(40);
        drain();
        set_config(1'b1, 1536, 512, 1530, 512);
        random_phase(65);
        // Mode flip after the previous spectrum has been closed and drained.
        drain();
        write_reg(CFG_REFLECTIVE, 0);
        random_phase(65);
        drain();
        for (int p = 0; p < 3; p++)
        begin
            cf = $urandom_range(900, 200);
            ifw = cf + $urandom_range(20) - 10;
            set_config(1'($urandom_range(1)), cf, $urandom_range(512, 100), ifw,
                       $urandom_range(512, 100));
            random_phase(55);
            drain();
        end

        $display("Covered %0d input transactions and %0d results over %0d random phases,",
                 items_sent, results_seen, phases_run);
        $display("including %0d zero-normalisation results and register extremes.",
                 zero_norm_results);
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Walks the pending rows of the directed table.
    task automatic run_directed_head();
        stim_row_t row;
        while (directed_rows.size() != 0)
        begin
            row = directed_rows.pop_front();
            send_item(row.item, row.typed, row.res);
        end
    endtask

endmodule
